FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the gravity step block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GSAT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GSAT_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define GSAT_ASSERT(name, prop, msg)
`define GSAT_ASSERT_NEVER(name, expr, msg)
`endif
`endif

FILE: rtl/core/gsat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gsat_pkg;

  localparam int unsigned POS_W = 28;
  localparam int unsigned VEL_W = 24;
  localparam int unsigned RAD_W = 4;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned CFG_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PLANET_SLOTS = 3;
  localparam int unsigned MAX_PLANETS_DEF = 3;

  // Squared distance in whole units and its root in Q.8.
  localparam int unsigned D2_W = 2 * COORD_W + 2;
  localparam int unsigned ROOT_W = 21;
  localparam int unsigned SQ_N_W = 2 * ROOT_W;
  localparam int unsigned SQ_REM_W = ROOT_W + 2;
  localparam int unsigned SQ_W = 2 * ROOT_W;
  localparam logic [ROOT_W-1:0] R8_MIN = ROOT_W'(256);

  // Divider: numerator is num << NUM_SHIFT, quotient fits QUO_W bits.
  localparam int unsigned CUBE_W = 62;
  localparam int unsigned NUM_W = 33;
  localparam int unsigned NUM_SHIFT = 24;
  localparam int unsigned QUO_W = 33;
  localparam int unsigned PULL_W = QUO_W + 1;

  localparam int unsigned LANE_LAT = 1 + ROOT_W + 3 + QUO_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT   = 3'd0,
    CFG_PLANET0 = 3'd1,
    CFG_PLANET1 = 3'd2,
    CFG_PLANET2 = 3'd3,
    CFG_WIDTH   = 3'd4,
    CFG_HEIGHT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]         g;
    logic [3:0]         r;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } planet_t;

  typedef struct packed {
    logic                     hit;
    logic signed [PULL_W-1:0] pull_x;
    logic signed [PULL_W-1:0] pull_y;
  } lane_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/gravity_satellite_step.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// One explicit Euler step of a satellite under up to three fixed planets. The block takes
// one item per clock while in_stall_o is low, and returns the results in order.
// Every planet has a lane of its own: a front stage that forms the distance, the contact
// test and the pull numerators, a chain of 21 square-root cells, three stages that build
// r^3, and two chains of 33 divider cells, one quotient bit each. The latency is set by
// those cell chains; while the skid register is empty the rate stays at one item per cycle,
// as every cell passes its partial result to its neighbor on each clock. A combine stage
// then applies the planets in order (contact zeroes the velocity, then the pull is added
// with saturation) and the position is advanced and wrapped at the field edges. An output
// register and a one-item skid register part the result channel from the pipeline, so the
// block keeps accepting while a finished item waits; in_stall_o is raised only when the
// skid register is full. Configuration registers are written through cfg_we_i,
// cfg_index_i and cfg_wdata_i and must only change while no item is in flight.
module gravity_satellite_step #(
  parameter int unsigned MAX_PLANETS = gsat_pkg::MAX_PLANETS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gsat_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gsat_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [gsat_pkg::POS_W-1:0]        pos_x_i,
  input  logic [gsat_pkg::POS_W-1:0]        pos_y_i,
  input  logic signed [gsat_pkg::VEL_W-1:0] vel_x_i,
  input  logic signed [gsat_pkg::VEL_W-1:0] vel_y_i,
  input  logic [gsat_pkg::RAD_W-1:0]        sat_radius_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [gsat_pkg::POS_W-1:0]        new_pos_x_o,
  output logic [gsat_pkg::POS_W-1:0]        new_pos_y_o,
  output logic signed [gsat_pkg::VEL_W-1:0] new_vel_x_o,
  output logic signed [gsat_pkg::VEL_W-1:0] new_vel_y_o,
  output logic                              hit_o
);
  import gsat_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [VEL_W-1:0] vel_x;
    logic [VEL_W-1:0] vel_y;
  } pay_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [VEL_W-1:0] vel_x;
    logic [VEL_W-1:0] vel_y;
    logic             hit;
  } res_t;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W - 1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W - 1){1'b0}}};

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [PULL_W:0] s);
    logic signed [VEL_W-1:0] r;
    if (s > (PULL_W + 1)'(VEL_MAX)) begin
      r = VEL_MAX;
    end else if (s < (PULL_W + 1)'(VEL_MIN)) begin
      r = VEL_MIN;
    end else begin
      r = s[VEL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] wrap_pos(input logic [POS_W-1:0] pos,
                                                input logic signed [VEL_W-1:0] vel,
                                                input logic [COORD_W-1:0] lim);
    logic signed [POS_W+1:0] p;
    logic signed [POS_W+1:0] l;
    logic [POS_W-1:0]        r;
    p = $signed({2'b00, pos}) + (POS_W + 2)'(vel);
    l = $signed({2'b00, lim, {FRAC_W{1'b0}}});
    if (p > l) begin
      r = '0;
    end else if (p < 0) begin
      r = {lim, {FRAC_W{1'b0}}};
    end else begin
      r = p[POS_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [1:0]         planet_count_q;
  planet_t            planet_q [PLANET_SLOTS];
  logic [COORD_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planet_count_q <= 2'd1;
      for (int i = 0; i < PLANET_SLOTS; i++) begin
        planet_q[i] <= '0;
      end
      width_q  <= COORD_W'(160);
      height_q <= COORD_W'(96);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_COUNT:   planet_count_q <= cfg_wdata_i[1:0];
        CFG_PLANET0: planet_q[0] <= planet_t'(cfg_wdata_i);
        CFG_PLANET1: planet_q[1] <= planet_t'(cfg_wdata_i);
        CFG_PLANET2: planet_q[2] <= planet_t'(cfg_wdata_i);
        CFG_WIDTH:   width_q <= cfg_wdata_i[COORD_W-1:0];
        CFG_HEIGHT:  height_q <= cfg_wdata_i[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline moves together unless the skid register is holding an item.
  logic skid_full_q;
  logic en;
  logic accept;

  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;
  assign accept     = in_valid_i && !in_stall_o;

  // Input stage.
  logic             a_v_q;
  pay_t             a_q;
  logic [RAD_W-1:0] a_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q     <= '{pos_x: pos_x_i, pos_y: pos_y_i, vel_x: vel_x_i, vel_y: vel_y_i};
      a_rad_q <= sat_radius_i;
    end
  end

  // Planet lanes.
  lane_res_t lane_res [MAX_PLANETS];

  for (genvar k = 0; k < MAX_PLANETS; k++) begin : g_lane
    gsat_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .planet_i (planet_q[k]),
      .pos_x_i  (a_q.pos_x),
      .pos_y_i  (a_q.pos_y),
      .rad_i    (a_rad_q),
      .res_o    (lane_res[k])
    );
  end

  // The state and its valid bit travel beside the lanes.
  logic vld_q [LANE_LAT];
  pay_t dly_q [LANE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= a_v_q;
      for (int i = 1; i < LANE_LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= a_q;
      for (int i = 1; i < LANE_LAT; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  // Combine: the planets in use act in order on the velocity.
  logic [1:0] count_sat;
  res_t       c_d;

  assign count_sat = (planet_count_q > 2'(MAX_PLANETS)) ? 2'(MAX_PLANETS) : planet_count_q;

  always_comb begin
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic                    hit;
    vx  = $signed(dly_q[LANE_LAT-1].vel_x);
    vy  = $signed(dly_q[LANE_LAT-1].vel_y);
    hit = 1'b0;
    for (int k = 0; k < MAX_PLANETS; k++) begin
      if (k < int'(count_sat)) begin
        if (lane_res[k].hit) begin
          vx  = '0;
          vy  = '0;
          hit = 1'b1;
        end
        vx = sat_vel((PULL_W + 1)'(vx) + (PULL_W + 1)'(lane_res[k].pull_x));
        vy = sat_vel((PULL_W + 1)'(vy) + (PULL_W + 1)'(lane_res[k].pull_y));
      end
    end
    c_d.pos_x = dly_q[LANE_LAT-1].pos_x;
    c_d.pos_y = dly_q[LANE_LAT-1].pos_y;
    c_d.vel_x = vx;
    c_d.vel_y = vy;
    c_d.hit   = hit;
  end

  logic c_v_q;
  res_t c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= vld_q[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= c_d;
    end
  end

  // Position step and wrap, then into the output or skid register.
  res_t fin;

  always_comb begin
    fin.pos_x = wrap_pos(c_q.pos_x, $signed(c_q.vel_x), width_q);
    fin.pos_y = wrap_pos(c_q.pos_y, $signed(c_q.vel_y), height_q);
    fin.vel_x = c_q.vel_x;
    fin.vel_y = c_q.vel_y;
    fin.hit   = c_q.hit;
  end

  logic out_valid_q, out_valid_d;
  logic skid_full_d;
  logic incoming, out_take;
  logic load_out, load_skid, from_skid;
  res_t out_q, sk_q;

  always_comb begin
    incoming    = en && c_v_q;
    out_take    = out_valid_q && !out_stall_i;
    out_valid_d = out_valid_q;
    skid_full_d = skid_full_q;
    load_out    = 1'b0;
    load_skid   = 1'b0;
    from_skid   = 1'b0;
    if (skid_full_q) begin
      if (out_take) begin
        load_out    = 1'b1;
        from_skid   = 1'b1;
        skid_full_d = 1'b0;
      end
    end else if (incoming) begin
      if (out_valid_q && !out_take) begin
        load_skid   = 1'b1;
        skid_full_d = 1'b1;
      end else begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= from_skid ? sk_q : fin;
    end
    if (load_skid) begin
      sk_q <= fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_pos_x_o = out_q.pos_x;
  assign new_pos_y_o = out_q.pos_y;
  assign new_vel_x_o = $signed(out_q.vel_x);
  assign new_vel_y_o = $signed(out_q.vel_y);
  assign hit_o       = out_q.hit;

  // A held skid item always sits behind a held output item.
  `GSAT_ASSERT_NEVER(a_skid_without_out, skid_full_q && !out_valid_q, "skid full, output empty")
  // An item arriving at a stalled output must land in the skid register.
  `GSAT_ASSERT(a_stall_fills_skid,
    (out_valid_q && out_stall_i && !skid_full_q && c_v_q) |=> skid_full_q,
    "item lost at stalled output")
  // A drained skid item moves to the output in the next cycle.
  `GSAT_ASSERT(a_skid_drains, (skid_full_q && !out_stall_i) |=> (out_valid_q && !skid_full_q),
    "skid item not moved to output")
  // An accepted item enters the input stage.
  `GSAT_ASSERT(a_accept_loads, (in_valid_i && !in_stall_o) |=> a_v_q, "accepted item dropped")

endmodule
`default_nettype wire

FILE: rtl/core/gsat_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One digit of the integer square root of d2 << 16, two radicand bits a cell.
module gsat_sqrt_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [gsat_pkg::D2_W-1:0]     d2_i,
  input  logic [gsat_pkg::SQ_REM_W-1:0] rem_i,
  input  logic [gsat_pkg::ROOT_W-1:0]   root_i,
  output logic [gsat_pkg::D2_W-1:0]     d2_o,
  output logic [gsat_pkg::SQ_REM_W-1:0] rem_o,
  output logic [gsat_pkg::ROOT_W-1:0]   root_o
);
  import gsat_pkg::*;

  logic [SQ_N_W-1:0]   n;
  logic [1:0]          pair;
  logic [SQ_REM_W+1:0] rem_n;
  logic [SQ_REM_W+1:0] trial;
  logic                ge;
  logic [SQ_REM_W-1:0] rem_d;
  logic [ROOT_W-1:0]   root_d;

  always_comb begin
    n      = {d2_i, {(SQ_N_W - D2_W){1'b0}}};
    pair   = n[SQ_N_W-1-2*IDX -: 2];
    rem_n  = {rem_i, pair};
    trial  = (SQ_REM_W + 2)'({root_i, 2'b01});
    ge     = rem_n >= trial;
    rem_d  = ge ? SQ_REM_W'(rem_n - trial) : SQ_REM_W'(rem_n);
    root_d = {root_i[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_o   <= d2_i;
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/gsat_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One quotient bit of (num << 24) / cube, restoring form.
module gsat_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [gsat_pkg::CUBE_W-1:0] cube_i,
  input  logic [gsat_pkg::NUM_W-1:0]  num_i,
  input  logic [gsat_pkg::CUBE_W-1:0] rem_i,
  input  logic [gsat_pkg::QUO_W-1:0]  quo_i,
  output logic [gsat_pkg::CUBE_W-1:0] cube_o,
  output logic [gsat_pkg::NUM_W-1:0]  num_o,
  output logic [gsat_pkg::CUBE_W-1:0] rem_o,
  output logic [gsat_pkg::QUO_W-1:0]  quo_o
);
  import gsat_pkg::*;

  logic              nbit;
  logic [CUBE_W:0]   rem_n;
  logic [CUBE_W:0]   diff;
  logic              ge;
  logic [CUBE_W-1:0] rem_d;

  if (BIT >= NUM_SHIFT) begin : g_num_bit
    assign nbit = num_i[BIT-NUM_SHIFT];
  end else begin : g_zero_bit
    assign nbit = 1'b0;
  end

  always_comb begin
    rem_n = {rem_i, nbit};
    diff  = rem_n - {1'b0, cube_i};
    ge    = rem_n >= {1'b0, cube_i};
    rem_d = ge ? diff[CUBE_W-1:0] : rem_n[CUBE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cube_o <= cube_i;
      num_o  <= num_i;
      rem_o  <= rem_d;
      quo_o  <= {quo_i[QUO_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/gsat_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// Pull and contact test of one planet: front stage, root chain, cube, two divider chains.
module gsat_lane (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  gsat_pkg::planet_t            planet_i,
  input  logic [gsat_pkg::POS_W-1:0]   pos_x_i,
  input  logic [gsat_pkg::POS_W-1:0]   pos_y_i,
  input  logic [gsat_pkg::RAD_W-1:0]   rad_i,
  output gsat_pkg::lane_res_t          res_o
);
  import gsat_pkg::*;

  typedef struct packed {
    logic             hit;
    logic             neg_x;
    logic             neg_y;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
  } side_t;

  typedef struct packed {
    logic hit;
    logic neg_x;
    logic neg_y;
  } flag_t;

  localparam int unsigned SIDE_D = ROOT_W + 3;

  // Front stage.
  logic signed [COORD_W:0]     ex, ey;
  logic signed [2*COORD_W+1:0] ex_sq, ey_sq;
  logic [D2_W-1:0]             d2;
  logic [RAD_W:0]              rs;
  logic [2*RAD_W+1:0]          rs_sq;
  logic signed [POS_W:0]       dqx, dqy;
  logic [POS_W-1:0]            mag_x, mag_y;
  logic [RAD_W:0]              g2;
  side_t                       s1_d;

  always_comb begin
    ex    = $signed({1'b0, planet_i.x}) - $signed({1'b0, pos_x_i[POS_W-1 -: COORD_W]});
    ey    = $signed({1'b0, planet_i.y}) - $signed({1'b0, pos_y_i[POS_W-1 -: COORD_W]});
    ex_sq = ex * ex;
    ey_sq = ey * ey;
    d2    = D2_W'($unsigned(ex_sq)) + D2_W'($unsigned(ey_sq));
    rs    = {1'b0, rad_i} + {1'b0, planet_i.r};
    rs_sq = rs * rs;
    dqx   = $signed({1'b0, planet_i.x, {FRAC_W{1'b0}}}) - $signed({1'b0, pos_x_i});
    dqy   = $signed({1'b0, planet_i.y, {FRAC_W{1'b0}}}) - $signed({1'b0, pos_y_i});
    mag_x = dqx[POS_W] ? POS_W'(-dqx) : POS_W'(dqx);
    mag_y = dqy[POS_W] ? POS_W'(-dqy) : POS_W'(dqy);
    g2    = {planet_i.g, 1'b0};
    s1_d.hit   = d2 <= D2_W'(rs_sq);
    s1_d.neg_x = dqx[POS_W];
    s1_d.neg_y = dqy[POS_W];
    s1_d.num_x = NUM_W'(mag_x) * NUM_W'(g2);
    s1_d.num_y = NUM_W'(mag_y) * NUM_W'(g2);
  end

  logic [D2_W-1:0] d2_q;
  side_t           s1_q;
  side_t           side_q [SIDE_D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_q      <= d2;
      s1_q      <= s1_d;
      side_q[0] <= s1_q;
      for (int i = 1; i < SIDE_D; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Root chain.
  logic [D2_W-1:0]     sq_d2   [ROOT_W+1];
  logic [SQ_REM_W-1:0] sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]   sq_root [ROOT_W+1];

  assign sq_d2[0]   = d2_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    gsat_sqrt_cell #(.IDX(j)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .d2_i   (sq_d2[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .d2_o   (sq_d2[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1])
    );
  end

  // Clamp, square, cube.
  logic [ROOT_W-1:0] r8c;
  logic [ROOT_W-1:0] q1_r8_q;
  logic [SQ_W-1:0]   q1_sq_q;
  logic [SQ_W-1:0]   q2_lo_q, q2_hi_q;
  logic [CUBE_W-1:0] cube_q;

  assign r8c = (sq_root[ROOT_W] < R8_MIN) ? R8_MIN : sq_root[ROOT_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_r8_q <= r8c;
      q1_sq_q <= SQ_W'(r8c) * SQ_W'(r8c);
      q2_lo_q <= SQ_W'(q1_sq_q[ROOT_W-1:0]) * SQ_W'(q1_r8_q);
      q2_hi_q <= SQ_W'(q1_sq_q[SQ_W-1:ROOT_W]) * SQ_W'(q1_r8_q);
      cube_q  <= CUBE_W'({q2_hi_q, {ROOT_W{1'b0}}}) + CUBE_W'(q2_lo_q);
    end
  end

  // Divider chains, one quotient bit per cell.
  logic [CUBE_W-1:0] dx_cube [QUO_W+1];
  logic [NUM_W-1:0]  dx_num  [QUO_W+1];
  logic [CUBE_W-1:0] dx_rem  [QUO_W+1];
  logic [QUO_W-1:0]  dx_quo  [QUO_W+1];
  logic [CUBE_W-1:0] dy_cube [QUO_W+1];
  logic [NUM_W-1:0]  dy_num  [QUO_W+1];
  logic [CUBE_W-1:0] dy_rem  [QUO_W+1];
  logic [QUO_W-1:0]  dy_quo  [QUO_W+1];

  assign dx_cube[0] = cube_q;
  assign dx_num[0]  = side_q[SIDE_D-1].num_x;
  assign dx_rem[0]  = CUBE_W'(side_q[SIDE_D-1].num_x >> (QUO_W - NUM_SHIFT));
  assign dx_quo[0]  = '0;
  assign dy_cube[0] = cube_q;
  assign dy_num[0]  = side_q[SIDE_D-1].num_y;
  assign dy_rem[0]  = CUBE_W'(side_q[SIDE_D-1].num_y >> (QUO_W - NUM_SHIFT));
  assign dy_quo[0]  = '0;

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    gsat_div_cell #(.BIT(QUO_W - 1 - k)) u_x (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .cube_i (dx_cube[k]),
      .num_i  (dx_num[k]),
      .rem_i  (dx_rem[k]),
      .quo_i  (dx_quo[k]),
      .cube_o (dx_cube[k+1]),
      .num_o  (dx_num[k+1]),
      .rem_o  (dx_rem[k+1]),
      .quo_o  (dx_quo[k+1])
    );
    gsat_div_cell #(.BIT(QUO_W - 1 - k)) u_y (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .cube_i (dy_cube[k]),
      .num_i  (dy_num[k]),
      .rem_i  (dy_rem[k]),
      .quo_i  (dy_quo[k]),
      .cube_o (dy_cube[k+1]),
      .num_o  (dy_num[k+1]),
      .rem_o  (dy_rem[k+1]),
      .quo_o  (dy_quo[k+1])
    );
  end

  flag_t tail_q [QUO_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tail_q[0] <= '{hit: side_q[SIDE_D-1].hit, neg_x: side_q[SIDE_D-1].neg_x,
                     neg_y: side_q[SIDE_D-1].neg_y};
      for (int i = 1; i < QUO_W; i++) begin
        tail_q[i] <= tail_q[i-1];
      end
    end
  end

  logic signed [PULL_W-1:0] qx, qy;

  always_comb begin
    qx = $signed({1'b0, dx_quo[QUO_W]});
    qy = $signed({1'b0, dy_quo[QUO_W]});
    res_o.hit    = tail_q[QUO_W-1].hit;
    res_o.pull_x = tail_q[QUO_W-1].neg_x ? -qx : qx;
    res_o.pull_y = tail_q[QUO_W-1].neg_y ? -qy : qy;
  end

endmodule
`default_nettype wire

FILE: verif/gravity_satellite_step_test.sv
`timescale 1ns / 1ps
module gravity_satellite_step_test;
  import gsat_pkg::*;

  // Index past the end of the register list; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;
  // Drain allowance after the last result, a little above the pipeline depth.
  localparam int DRAIN_CYCLES = 70;

  typedef struct {
    logic [POS_W-1:0]        px;
    logic [POS_W-1:0]        py;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic [RAD_W-1:0]        rad;
  } sat_item_t;

  typedef struct {
    logic [POS_W-1:0]        px;
    logic [POS_W-1:0]        py;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic                    hit;
  } sat_state_t;

  // A directed row either carries a hand-written result or leaves it to the predictor.
  typedef struct {
    sat_item_t  item;
    logic       typed;
    sat_state_t want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [POS_W-1:0] pos_x = '0, pos_y = '0;
  logic signed [VEL_W-1:0] vel_x = '0, vel_y = '0;
  logic [RAD_W-1:0] sat_radius = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [POS_W-1:0] new_pos_x, new_pos_y;
  logic signed [VEL_W-1:0] new_vel_x, new_vel_y;
  logic hit;

  // Shadow copy of the configuration, tracked by every write the test makes.
  logic [1:0] planet_cnt = 2'd1;
  logic [CFG_W-1:0] planet_w [PLANET_SLOTS] = '{default: '0};
  logic [COORD_W-1:0] field_w = 12'd160;
  logic [COORD_W-1:0] field_h = 12'd96;

  sat_state_t pending_steps[$];
  int errors = 0;
  // While calm is set neither side idles.
  logic calm = 1'b0;

  gravity_satellite_step dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .vel_x_i(vel_x), .vel_y_i(vel_y),
    .sat_radius_i(sat_radius),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .new_pos_x_o(new_pos_x), .new_pos_y_o(new_pos_y),
    .new_vel_x_o(new_vel_x), .new_vel_y_o(new_vel_y), .hit_o(hit)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Integer square root, bit by bit, as the distance root is defined.
  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp_vel(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Pull on one axis: 2*g*d*2^24 / r8^3, truncated toward zero, sign of d.
  function automatic longint axis_pull(longint unsigned g, longint d, longint unsigned cube);
    longint unsigned mag, q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = ((64'd2 * g * mag) << 24) / cube;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [POS_W-1:0] wrap_axis(longint p, logic [COORD_W-1:0] lim_whole);
    longint lim;
    lim = longint'(lim_whole) << 16;
    if (p > lim) return '0;
    if (p < 0) return lim[POS_W-1:0];
    return p[POS_W-1:0];
  endfunction

  // Euler step of one satellite under the planets currently configured.
  function automatic sat_state_t euler_step(sat_item_t it);
    sat_state_t r;
    longint vx, vy, ix, iy, ppx, ppy, ex, ey;
    longint unsigned d2, rs, r8, cube, g, pr;
    logic [CFG_W-1:0] w;
    vx = longint'(it.vx);
    vy = longint'(it.vy);
    ix = longint'(it.px >> 16);
    iy = longint'(it.py >> 16);
    r.hit = 1'b0;
    for (int k = 0; k < int'(planet_cnt) && k < int'(PLANET_SLOTS); k++) begin
      w = planet_w[k];
      ppx = longint'(w[11:0]);
      ppy = longint'(w[23:12]);
      pr = longint'(w[27:24]);
      g = longint'(w[31:28]);
      ex = ppx - ix;
      ey = ppy - iy;
      d2 = ex * ex + ey * ey;
      rs = longint'(it.rad) + pr;
      // Contact, the boundary distance included, kills the velocity first.
      if (d2 <= rs * rs) begin
        vx = 0;
        vy = 0;
        r.hit = 1'b1;
      end
      r8 = int_root(d2 << 16);
      if (r8 < 256) r8 = 256;
      cube = r8 * r8 * r8;
      vx = clamp_vel(vx + axis_pull(g, (ppx <<< 16) - longint'(it.px), cube));
      vy = clamp_vel(vy + axis_pull(g, (ppy <<< 16) - longint'(it.py), cube));
    end
    r.px = wrap_axis(longint'(it.px) + vx, field_w);
    r.py = wrap_axis(longint'(it.py) + vy, field_h);
    r.vx = vx[VEL_W-1:0];
    r.vy = vy[VEL_W-1:0];
    return r;
  endfunction

  // Register write; the caller lowers the enable after its last write.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_COUNT:   planet_cnt = data[1:0];
      CFG_PLANET0: planet_w[0] = data;
      CFG_PLANET1: planet_w[1] = data;
      CFG_PLANET2: planet_w[2] = data;
      CFG_WIDTH:   field_w = data[COORD_W-1:0];
      CFG_HEIGHT:  field_h = data[COORD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Send one item; valid stays high afterwards so back-to-back items need no gap.
  task automatic send_item(sat_item_t it, logic typed, sat_state_t want);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= it.px;
    pos_y <= it.py;
    vel_x <= it.vx;
    vel_y <= it.vy;
    sat_radius <= it.rad;
    do @(posedge clk); while (in_stall);
    pending_steps = {pending_steps, typed ? want : euler_step(it)};
  endtask

  // Stop sending and wait for every outstanding result plus the pipeline tail.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] rand_planet();
    logic [CFG_W-1:0] w;
    w = $urandom;
    w[11:0] = COORD_W'($urandom_range(int'(field_w)));
    w[23:12] = COORD_W'($urandom_range(int'(field_h)));
    return w;
  endfunction

  // Mostly satellites placed close to one of the planet slots, the rest anywhere.
  function automatic sat_item_t rand_item();
    sat_item_t it;
    logic [CFG_W-1:0] w;
    logic [COORD_W-1:0] cx, cy;
    it.px = POS_W'($urandom);
    it.py = POS_W'($urandom);
    it.vx = VEL_W'($urandom);
    it.vy = VEL_W'($urandom);
    it.rad = RAD_W'($urandom);
    if ($urandom_range(99) < 70) begin
      w = planet_w[$urandom_range(PLANET_SLOTS - 1)];
      cx = w[11:0] + COORD_W'($urandom_range(40)) - COORD_W'(20);
      cy = w[23:12] + COORD_W'($urandom_range(40)) - COORD_W'(20);
      it.px = {cx, 16'($urandom)};
      it.py = {cy, 16'($urandom)};
      if ($urandom_range(99) < 80) begin
        it.vx = VEL_W'($urandom_range(6 << 16)) - VEL_W'(3 << 16);
        it.vy = VEL_W'($urandom_range(6 << 16)) - VEL_W'(3 << 16);
      end
    end
    return it;
  endfunction

  task automatic random_items(int n, int calm_from, int calm_to);
    sat_state_t none;
    none = '{default: '0};
    for (int i = 0; i < n; i++) begin
      calm = (i >= calm_from && i < calm_to);
      send_item(rand_item(), 1'b0, none);
    end
    calm = 1'b0;
  endtask

  // Directed rows run under the reset configuration: one planet at the origin,
  // no radius, no gravity, field 160 by 96.
  step_row_t dir_rows[] = '{
    // Satellite on the planet: contact with a zero sum of radii.
    '{'{28'h0, 28'h0, 24'sh0, 24'sh0, 4'd0}, 1'b1,
      '{28'h0, 28'h0, 24'sh0, 24'sh0, 1'b1}},
    // Clear of the planet and at rest: nothing moves.
    '{'{28'h00A0000, 28'h0140000, 24'sh0, 24'sh0, 4'd0}, 1'b1,
      '{28'h00A0000, 28'h0140000, 24'sh0, 24'sh0, 1'b0}},
    // Largest position and velocity: past the far edge, wraps to zero.
    '{'{28'hFFFFFFF, 28'hFFFFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 4'd15}, 1'b1,
      '{28'h0, 28'h0, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0}},
    // Most negative velocity: below zero, goes to the field limit.
    '{'{28'h0050000, 28'h0050000, -24'sh800000, -24'sh800000, 4'd0}, 1'b1,
      '{28'h0A00000, 28'h0600000, -24'sh800000, -24'sh800000, 1'b0}},
    // Distance exactly the sum of radii counts as contact.
    '{'{28'h0030000, 28'h0040000, 24'sh010000, 24'sh010000, 4'd5}, 1'b1,
      '{28'h0030000, 28'h0040000, 24'sh0, 24'sh0, 1'b1}},
    // One unit short of contact.
    '{'{28'h0030000, 28'h0040000, 24'sh010000, 24'sh010000, 4'd4}, 1'b0,
      '{default: '0}},
    // Landing exactly on the limit stays there.
    '{'{28'h09F8000, 28'h05F8000, 24'sh008000, 24'sh008000, 4'd1}, 1'b0,
      '{default: '0}},
    // Position beyond the field on input, moving back.
    '{'{28'hC000000, 28'h8000000, -24'sh010000, 24'sh0, 4'd2}, 1'b0,
      '{default: '0}},
    '{'{28'h0000001, 28'h0000001, -24'sh000002, 24'sh000001, 4'd0}, 1'b0,
      '{default: '0}},
    '{'{28'h5555555, 28'hAAAAAAA, 24'sh555555, -24'sh2AAAAB, 4'd10}, 1'b0,
      '{default: '0}}
  };

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    drain();

    // Two planets at their strongest, one at the far corner, and a random third; largest field.
    // The count write carries extra high bits that must be masked off.
    cfg_write(CFG_COUNT, 32'hFFFF_FFFF);
    cfg_write(CFG_WIDTH, 32'd4095);
    cfg_write(CFG_HEIGHT, 32'd4095);
    cfg_write(CFG_PLANET0, 32'hFFFF_FFFF);
    cfg_write(CFG_PLANET1, {4'd15, 4'd15, 12'd50, 12'd80});
    cfg_write(CFG_PLANET2, rand_planet());
    cfg_write(CFG_SPARE, 32'h1234_5678);
    cfg_done();
    random_items(100, 0, 0);
    drain();

    // No planet in use and a field of zero size.
    cfg_write(CFG_COUNT, 32'd0);
    cfg_write(CFG_WIDTH, 32'd0);
    cfg_write(CFG_HEIGHT, 32'd0);
    cfg_done();
    random_items(50, 0, 0);
    drain();

    // Two planets, a field one unit wide.
    cfg_write(CFG_COUNT, 32'd2);
    cfg_write(CFG_WIDTH, 32'd1);
    cfg_write(CFG_HEIGHT, 32'd4095);
    cfg_write(CFG_PLANET0, rand_planet());
    cfg_write(CFG_PLANET1, rand_planet());
    cfg_done();
    random_items(100, 0, 0);
    drain();

    // Back to the default field with three random planets inside it.
    cfg_write(CFG_WIDTH, 32'd160);
    cfg_write(CFG_HEIGHT, 32'd96);
    cfg_write(CFG_COUNT, 32'd3);
    cfg_write(CFG_PLANET0, rand_planet());
    cfg_write(CFG_PLANET1, rand_planet());
    cfg_write(CFG_PLANET2, rand_planet());
    cfg_done();
    random_items(200, 60, 160);
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: random stalls, and every accepted result checked in order.
  always @(posedge clk) begin
    sat_state_t w;
    if (rst_n) begin
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);
      if (out_valid && !out_stall) begin
        if (pending_steps.size() == 0) begin
          $display("%0t: result with nothing expected", $time);
          errors++;
        end else begin
          w = pending_steps.pop_front();
          if (new_pos_x !== w.px) begin
            $display("%0t: new_pos_x expected %h got %h", $time, w.px, new_pos_x);
            errors++;
          end
          if (new_pos_y !== w.py) begin
            $display("%0t: new_pos_y expected %h got %h", $time, w.py, new_pos_y);
            errors++;
          end
          if (new_vel_x !== w.vx) begin
            $display("%0t: new_vel_x expected %h got %h", $time, w.vx, new_vel_x);
            errors++;
          end
          if (new_vel_y !== w.vy) begin
            $display("%0t: new_vel_y expected %h got %h", $time, w.vy, new_vel_y);
            errors++;
          end
          if (hit !== w.hit) begin
            $display("%0t: hit expected %b got %b", $time, w.hit, hit);
            errors++;
          end
        end
      end
    end
  end

endmodule
